@@ hdl/request_response_latency_tracker_unit_macros.svh @@
// ----------------------------------------------------------------------------
// request/response latency tracker assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef REQUEST_RESPONSE_LATENCY_TRACKER_UNIT_MACROS_SVH
`define REQUEST_RESPONSE_LATENCY_TRACKER_UNIT_MACROS_SVH
`ifndef SYNTH
`define RRLT_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("rrlt assertion failed");
`define RRLT_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("rrlt assertion failed");
`else
`define RRLT_ASSERT_IMP(lbl, a, b)
`define RRLT_ASSERT_NXT(lbl, a, b)
`endif
`endif

@@ hdl/rrlt_pkg.sv @@
// ----------------------------------------------------------------------------
// rrlt_pkg
// shared types, codes and constants of the latency tracker
// ----------------------------------------------------------------------------
package rrlt_pkg;

    localparam int TABLE_ENTRIES = 2048;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int FILL_W        = IDX_W + 1;
    localparam int CFG_IDX_W     = 1;

    localparam logic [1:0] KIND_REQ = 2'd0;
    localparam logic [1:0] KIND_RSP = 2'd1;
    localparam logic [1:0] KIND_CLR = 2'd2;

    localparam logic [2:0] ST_RECORDED = 3'd0;
    localparam logic [2:0] ST_MATCHED  = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 1'd1;

    localparam logic [29:0] WINDOW_RESET = 30'd200000000;
    localparam logic [29:0] SLOW_RESET   = 30'd50000000;
    localparam logic signed [30:0] NS_PER_SEC = 31'sd1000000000;
    localparam logic [11:0] ACTIVE_MAX = 12'd4095;

    typedef struct packed {
        logic [1:0]  kind;
        logic        table_select;
        logic [31:0] flow_addr;
        logic [15:0] flow_port;
        logic [31:0] seq_number;
        logic [15:0] packet_length;
        logic [31:0] stamp_sec;
        logic [29:0] stamp_nsec;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [29:0] latency_ns;
        logic        sample_valid;
        logic        is_slow;
        logic [11:0] active_flows;
        logic [31:0] request_count;
        logic [31:0] response_count;
        logic [31:0] slow_count;
    } t_out_item;

    typedef struct packed {
        logic [48:0] key;
        logic [31:0] seq;
        logic [61:0] stamp;
    } t_entry;

    typedef struct packed {
        logic load;
        logic rd;
        logic hit;
        logic inc;
        logic clr;
        logic mul;
        logic fin;
    } t_ctrl_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_kind;
        logic       fill_zero;
        logic       match;
        logic       last;
        logic       out_busy;
    } t_ctrl_sts;

endpackage

@@ hdl/rrlt_if.sv @@
// ----------------------------------------------------------------------------
// rrlt channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface rrlt_in_if;
    import rrlt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rrlt_out_if;
    import rrlt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/rrlt_datapath.sv @@
// ----------------------------------------------------------------------------
// rrlt_datapath
// flow table memory, latency arithmetic, counters and result register
// ----------------------------------------------------------------------------
module rrlt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrlt_pkg::t_ctrl_cmd           i_cmd,
    output rrlt_pkg::t_ctrl_sts           o_sts,
    input  logic                          i_in_valid,
    input  rrlt_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rrlt_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_we,
    input  logic [rrlt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [29:0]                   i_cfg_data
);
    import rrlt_pkg::*;
    `include "request_response_latency_tracker_unit_macros.svh"

    t_entry       mem_ent [TABLE_ENTRIES];
    logic         mem_act [TABLE_ENTRIES];

    logic [29:0]  r_window, r_slowlim;
    t_in_item     r_item;
    logic [IDX_W-1:0]  r_idx;
    logic [FILL_W-1:0] r_fill;
    logic         r_hit;
    t_entry       r_rd_ent;
    logic         r_rd_act;
    logic         r_full, r_new_act, r_reject;
    logic signed [63:0] r_prod;
    logic signed [30:0] r_ndiff;
    logic [11:0]  r_active;
    logic [31:0]  r_reqs, r_rsps, r_slows;
    logic         r_out_valid;
    t_out_item    r_out;

    logic [48:0]  w_key;
    logic         w_full;
    logic [IDX_W-1:0] w_slot;
    t_entry       w_old, w_new;
    logic         w_old_act, w_upd;
    logic signed [32:0] w_sdiff;
    logic signed [64:0] w_lat;
    logic         w_valid, w_slow, w_is_req, w_is_rsp;
    logic [11:0]  n_active;
    logic [31:0]  n_reqs, n_rsps, n_slows;
    logic [2:0]   w_status;

    assign w_key  = {r_item.table_select, r_item.flow_addr, r_item.flow_port};
    assign w_full = !r_hit && (r_fill == FILL_W'(TABLE_ENTRIES));
    assign w_slot = r_hit ? r_idx : r_fill[IDX_W-1:0];
    assign w_old  = r_hit ? r_rd_ent : t_entry'{key: w_key, seq: 32'd0, stamp: 62'd0};
    assign w_old_act = r_hit ? r_rd_act : 1'b0;
    assign w_upd  = w_old.seq < r_item.seq_number;
    assign w_new  = '{key: w_key,
                      seq: w_upd ? r_item.seq_number : w_old.seq,
                      stamp: w_upd ? {r_item.stamp_sec, r_item.stamp_nsec} : w_old.stamp};
    assign w_sdiff = $signed({1'b0, r_item.stamp_sec}) - $signed({1'b0, r_rd_ent.stamp[61:30]});

    assign w_is_req = r_item.kind == KIND_REQ;
    assign w_is_rsp = r_item.kind == KIND_RSP;
    assign w_lat   = {r_prod[63], r_prod} + {{34{r_ndiff[30]}}, r_ndiff};
    assign w_valid = w_is_rsp && !r_reject && !w_lat[64] && (w_lat != 65'sd0)
                     && (w_lat < $signed({35'd0, r_window}));
    assign w_slow  = w_valid && (w_lat > $signed({35'd0, r_slowlim}));

    always_comb begin
        n_reqs  = r_reqs + 32'(w_is_req);
        n_rsps  = r_rsps + 32'(w_is_rsp);
        n_slows = r_slows + 32'(w_slow);
        n_active = r_active;
        if (r_item.kind == KIND_CLR) begin
            n_active = 12'd0;
        end else if (w_is_req && r_new_act && r_active < ACTIVE_MAX) begin
            n_active = r_active + 12'd1;
        end
        case (r_item.kind)
            KIND_REQ: w_status = r_full ? ST_FULL : ST_RECORDED;
            KIND_RSP: w_status = r_reject ? ST_REJECTED : ST_MATCHED;
            default:  w_status = ST_CLEARED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_ent <= mem_ent[r_idx];
            r_rd_act <= mem_act[r_idx];
        end
        if (i_cmd.clr) begin
            mem_act[r_idx] <= 1'b0;
        end
        if (i_cmd.mul && w_is_req && !w_full) begin
            mem_ent[w_slot] <= w_new;
            mem_act[w_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.mul) begin
            r_full    <= w_full;
            r_new_act <= !w_full && !w_old_act;
            r_reject  <= !r_hit || ((r_item.seq_number - r_rd_ent.seq)
                         > {16'd0, r_item.packet_length});
            r_prod    <= 64'(w_sdiff) * 64'(NS_PER_SEC);
            r_ndiff   <= $signed({1'b0, r_item.stamp_nsec})
                         - $signed({1'b0, r_rd_ent.stamp[29:0]});
        end
        if (i_cmd.fin) begin
            r_out <= '{status: w_status,
                       latency_ns: w_valid ? w_lat[29:0] : 30'd0,
                       sample_valid: w_valid,
                       is_slow: w_slow,
                       active_flows: n_active,
                       request_count: n_reqs,
                       response_count: n_rsps,
                       slow_count: n_slows};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_slowlim   <= SLOW_RESET;
            r_idx       <= '0;
            r_fill      <= '0;
            r_hit       <= 1'b0;
            r_active    <= '0;
            r_reqs      <= '0;
            r_rsps      <= '0;
            r_slows     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WINDOW: r_window  <= i_cfg_data;
                    CFG_SLOW:   r_slowlim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else if (i_cmd.inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.hit) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.mul && w_is_req && w_full == 1'b0 && !r_hit) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (i_cmd.fin) begin
                r_active    <= n_active;
                r_reqs      <= n_reqs;
                r_rsps      <= n_rsps;
                r_slows     <= n_slows;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts = '{in_valid: i_in_valid,
                     in_kind: i_in_data.kind,
                     fill_zero: r_fill == '0,
                     match: r_rd_ent.key == w_key,
                     last: FILL_W'(r_idx) == r_fill - FILL_W'(1),
                     out_busy: r_out_valid && !i_out_ready};
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RRLT_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= FILL_W'(TABLE_ENTRIES))
    `RRLT_ASSERT_IMP(a_fin_room, i_cmd.fin, !r_out_valid || i_out_ready)
    `RRLT_ASSERT_NXT(a_fill_step, i_cmd.mul && w_is_req && !w_full && !r_hit,
                     r_fill == $past(r_fill) + FILL_W'(1))
endmodule

@@ hdl/rrlt_controller.sv @@
// ----------------------------------------------------------------------------
// rrlt_controller
// sequencer for table scan, active mark sweep, arithmetic and result write
// ----------------------------------------------------------------------------
module rrlt_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrlt_pkg::t_ctrl_sts i_sts,
    output rrlt_pkg::t_ctrl_cmd o_cmd,
    output logic                o_in_ready
);
    import rrlt_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_CLR, S_MUL, S_FIN} t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_sts.in_kind)
                        KIND_REQ, KIND_RSP: n_state = i_sts.fill_zero ? S_MUL : S_RD;
                        KIND_CLR: n_state = i_sts.fill_zero ? S_FIN : S_CLR;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (i_sts.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_MUL;
                end else if (i_sts.last) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = S_RD;
                end
            end
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.inc = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

@@ hdl/request_response_latency_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// request_response_latency_tracker_unit
// flow table based request/response latency tracker
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A request or response walks the
// single-port flow table memory entry by entry (read, then compare) until it
// hits the matching entry or passes the last stored one; a period clear
// sweeps the active marks one entry a cycle. The next transaction is accepted
// in the cycle after a result is written at the earliest. Table occupancy is
// kept as a fill count, so no clearing pass runs after reset. A result waits
// in an output register and the next transaction is accepted while it waits.
module request_response_latency_tracker_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rrlt_in_if.sink                        i_in,
    rrlt_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [rrlt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [29:0]                    i_cfg_data
);
    import rrlt_pkg::*;

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;
    logic      w_in_ready;

    assign i_in.ready = w_in_ready;

    rrlt_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    rrlt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_valid  (i_in.valid),
        .i_in_data   (i_in.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );
endmodule

@@ tb/request_response_latency_tracker_unit_tb.sv @@
// ----------------------------------------------------------------------------
// request_response_latency_tracker_unit_tb
// drives request, response, period clear and ignored transactions through the
// tracker under random stalls on both channels, predicts every result from a
// flow table kept here, and compares each result field by field
// ----------------------------------------------------------------------------
module request_response_latency_tracker_unit_tb;
    import rrlt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam int POOL = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam int STALL_CYCLES = 300;
    localparam longint NS = 64'd1000000000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [29:0] cfg_data;

    rrlt_in_if in_ch();
    rrlt_out_if out_ch();

    request_response_latency_tracker_unit dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in(in_ch),
        .o_out(out_ch),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // flow table as predicted
    logic [48:0] flow_keys [TABLE_ENTRIES];
    logic [31:0] flow_max_seq [TABLE_ENTRIES];
    logic [61:0] flow_stamp [TABLE_ENTRIES];
    bit flow_active [TABLE_ENTRIES];
    int flows_stored;
    logic [11:0] active_total;
    logic [31:0] requests_seen, responses_seen, slow_seen;
    logic [29:0] window_ns, slow_ns;

    t_in_item pending_items[$];
    t_out_item expected_results[$];
    t_out_item predicted;
    t_out_item wanted;
    int items_accepted, results_checked, mismatches, idle_cycles;
    int matched_seen, full_seen;
    int stall_requests, stall_served, stall_left;

    function automatic int find_flow(logic [48:0] key);
        for (int i = 0; i < flows_stored; i++) begin
            if (flow_keys[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic bit track_packet(t_in_item p, output t_out_item r);
        logic [48:0] key;
        logic [31:0] ahead;
        longint lat;
        int s;
        r = '0;
        key = {p.table_select, p.flow_addr, p.flow_port};
        if (p.kind == KIND_IGNORED) return 0;
        case (p.kind)
            KIND_REQ: begin
                requests_seen++;
                s = find_flow(key);
                if (s < 0 && flows_stored < TABLE_ENTRIES) begin
                    s = flows_stored++;
                    flow_keys[s] = key;
                    flow_max_seq[s] = '0;
                    flow_stamp[s] = '0;
                    flow_active[s] = 0;
                end
                if (s < 0) begin
                    r.status = ST_FULL;
                end else begin
                    r.status = ST_RECORDED;
                    if (!flow_active[s]) begin
                        flow_active[s] = 1;
                        if (active_total < ACTIVE_MAX) active_total++;
                    end
                    if (flow_max_seq[s] < p.seq_number) begin
                        flow_max_seq[s] = p.seq_number;
                        flow_stamp[s] = {p.stamp_sec, p.stamp_nsec};
                    end
                end
            end
            KIND_RSP: begin
                responses_seen++;
                s = find_flow(key);
                if (s >= 0) ahead = p.seq_number - flow_max_seq[s];
                if (s < 0 || ahead > {16'd0, p.packet_length}) begin
                    r.status = ST_REJECTED;
                end else begin
                    r.status = ST_MATCHED;
                    lat = (longint'({32'd0, p.stamp_sec}) - longint'({32'd0, flow_stamp[s][61:30]}))
                          * NS + (longint'({34'd0, p.stamp_nsec})
                          - longint'({34'd0, flow_stamp[s][29:0]}));
                    if (lat > 0 && lat < longint'({34'd0, window_ns})) begin
                        r.sample_valid = 1'b1;
                        r.latency_ns = lat[29:0];
                        if (lat > longint'({34'd0, slow_ns})) begin
                            r.is_slow = 1'b1;
                            slow_seen++;
                        end
                    end
                end
            end
            default: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) flow_active[i] = 0;
                active_total = '0;
                r.status = ST_CLEARED;
            end
        endcase
        r.active_flows = active_total;
        r.request_count = requests_seen;
        r.response_count = responses_seen;
        r.slow_count = slow_seen;
        return 1;
    endfunction

    function automatic bit take_idle();
        if (items_accepted >= 600 && items_accepted < 850) return 0;
        return $urandom_range(0, 99) < 19;
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                items_accepted++;
                if (track_packet(in_ch.data, predicted)) expected_results.push_back(predicted);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_items.size() > 0 && !take_idle()) begin
                    in_ch.data <= pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor, receiver stalls and watchdog
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: %p", out_ch.data);
                end else begin
                    wanted = expected_results.pop_front();
                    if (out_ch.data.status == ST_MATCHED) matched_seen++;
                    if (out_ch.data.status == ST_FULL) full_seen++;
                    if (out_ch.data.status !== wanted.status
                        || out_ch.data.latency_ns !== wanted.latency_ns
                        || out_ch.data.sample_valid !== wanted.sample_valid
                        || out_ch.data.is_slow !== wanted.is_slow
                        || out_ch.data.active_flows !== wanted.active_flows
                        || out_ch.data.request_count !== wanted.request_count
                        || out_ch.data.response_count !== wanted.response_count
                        || out_ch.data.slow_count !== wanted.slow_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", wanted, out_ch.data);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (stall_served != stall_requests) begin
                stall_served++;
                stall_left = STALL_CYCLES;
            end
            out_ch.ready <= (stall_left == 0) && !take_idle();
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout with %0d results outstanding", expected_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // stimulus generation
    logic [48:0] pool_key [POOL];
    logic [31:0] pool_seq [POOL];
    longint pool_time [POOL];
    longint now_ns;

    task automatic queue_item(logic [1:0] kind, logic [48:0] key, logic [31:0] seq,
                              logic [15:0] plen, logic [31:0] sec, logic [29:0] nsec);
        t_in_item p;
        p.kind = kind;
        {p.table_select, p.flow_addr, p.flow_port} = key;
        p.seq_number = seq;
        p.packet_length = plen;
        p.stamp_sec = sec;
        p.stamp_nsec = nsec;
        pending_items.push_back(p);
    endtask

    task automatic queue_timed(logic [1:0] kind, logic [48:0] key, logic [31:0] seq,
                               logic [15:0] plen, longint t);
        if (t < 0) t = 0;
        queue_item(kind, key, seq, plen, 32'(t / NS), 30'(t % NS));
    endtask

    task automatic drain();
        do @(negedge clk);
        while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_limits(logic [29:0] window, logic [29:0] slow);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_WINDOW;
        cfg_data <= window;
        @(posedge clk);
        cfg_index <= CFG_SLOW;
        cfg_data <= slow;
        @(posedge clk);
        cfg_we <= 1'b0;
        window_ns = window;
        slow_ns = slow;
    endtask

    function automatic longint pick_latency();
        case ($urandom_range(0, 7))
            0: return $urandom_range(1, 1000);
            1: return longint'(slow_ns) + $urandom_range(0, 10) - 5;
            2: return longint'(window_ns) + $urandom_range(0, 10) - 5;
            3: return 0;
            4: return -longint'($urandom_range(1, 1000000));
            default: return $urandom_range(1, window_ns + window_ns / 4 + 1);
        endcase
    endfunction

    task automatic random_phase(int count);
        int k;
        logic [15:0] plen;
        logic [31:0] seq;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, POOL - 1);
            now_ns += $urandom_range(0, 5000);
            case ($urandom_range(0, 99)) inside
                [0:39]: begin
                    if ($urandom_range(0, 9) == 0) seq = pool_seq[k] - $urandom_range(0, 50);
                    else seq = pool_seq[k] + $urandom_range(1, 3000);
                    if (seq > pool_seq[k]) begin
                        pool_seq[k] = seq;
                        pool_time[k] = now_ns;
                    end
                    queue_timed(KIND_REQ, pool_key[k], seq, 16'($urandom), now_ns);
                end
                [40:74]: begin
                    plen = 16'($urandom_range(0, 1500));
                    if ($urandom_range(0, 9) == 0) seq = pool_seq[k] + plen + $urandom_range(1, 9);
                    else seq = pool_seq[k] + $urandom_range(0, plen);
                    queue_timed(KIND_RSP, pool_key[k], seq, plen, pool_time[k] + pick_latency());
                end
                [75:81]: queue_item(KIND_REQ, 49'({$urandom, $urandom}), $urandom,
                                    16'($urandom), $urandom, 30'($urandom));
                [82:91]: queue_item(KIND_RSP, $urandom_range(0, 1) ? pool_key[k] :
                                    49'({$urandom, $urandom}), $urandom, 16'($urandom),
                                    $urandom, 30'($urandom));
                [92:95]: queue_item(KIND_CLR, 49'({$urandom, $urandom}), $urandom,
                                    16'($urandom), $urandom, 30'($urandom));
                default: begin
                    queue_item(KIND_IGNORED, 49'({$urandom, $urandom}), $urandom,
                               16'($urandom), $urandom, 30'($urandom));
                    n--;
                end
            endcase
        end
    endtask

    initial begin
        logic [48:0] k0, k1, k2;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WINDOW;
        cfg_data = '0;
        flows_stored = 0;
        active_total = '0;
        requests_seen = '0;
        responses_seen = '0;
        slow_seen = '0;
        window_ns = WINDOW_RESET;
        slow_ns = SLOW_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        k0 = {1'b0, 32'h0A000001, 16'd80};
        k1 = {1'b1, 32'hFFFFFFFF, 16'hFFFF};
        k2 = '0;
        queue_item(KIND_REQ, k0, 100, 0, 10, 5000);
        queue_item(KIND_RSP, k0, 150, 100, 10, 6000);
        queue_item(KIND_RSP, k0, 300, 100, 10, 6000);
        queue_item(KIND_RSP, {1'b1, k0[47:0]}, 150, 100, 10, 6000);
        queue_item(KIND_REQ, k0, 50, 0, 20, 0);
        queue_item(KIND_RSP, k0, 100, 0, 10, 5000);
        queue_item(KIND_RSP, k0, 100, 0, 9, 5000);
        queue_item(KIND_RSP, k0, 100, 0, 10, 60005000);
        queue_item(KIND_RSP, k0, 100, 0, 11, 5000);
        queue_item(KIND_IGNORED, k0, 200, 0, 30, 0);
        queue_item(KIND_REQ, k1, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 30'h3FFFFFFF);
        queue_item(KIND_RSP, k1, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 30'h3FFFFFFF);
        queue_item(KIND_RSP, k1, 0, 16'hFFFF, 32'hFFFFFFFF, 30'h3FFFFFFF);
        queue_item(KIND_REQ, k2, 0, 0, 0, 0);
        queue_item(KIND_RSP, k2, 0, 0, 0, 1);
        queue_item(KIND_CLR, k2, 0, 0, 0, 0);
        queue_item(KIND_REQ, k0, 200, 0, 100, 0);
        queue_item(KIND_RSP, k0, 200, 0, 100, 199999999);
        queue_item(KIND_RSP, k0, 200, 0, 100, 200000000);
        queue_item(KIND_RSP, k0, 200, 0, 100, 50000000);
        queue_item(KIND_IGNORED, k1, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 30'h3FFFFFFF);
        queue_item(KIND_CLR, k1, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 30'h3FFFFFFF);
        drain();

        now_ns = longint'($urandom_range(0, 1000000)) * NS;
        for (int i = 0; i < POOL; i++) begin
            pool_key[i] = 49'({$urandom, $urandom});
            pool_seq[i] = $urandom;
            pool_time[i] = now_ns;
        end

        random_phase(350);
        drain();
        set_limits(30'h3FFFFFFF, 30'd0);
        random_phase(350);
        drain();
        set_limits(30'd0, 30'h3FFFFFFF);
        random_phase(350);
        stall_requests++;
        drain();
        set_limits(30'd5000000, 30'd1000000);
        random_phase(350);
        drain();
        set_limits(30'd1000000000, 30'd100000000);
        random_phase(60);
        drain();

        // lookup miss, then known flows before and after a period clear
        queue_item(KIND_RSP, {1'b0, 32'hC0A80000 + TABLE_ENTRIES + 2, 16'h1F90}, 0, 16'hFFFF,
                   0, 0);
        queue_timed(KIND_REQ, pool_key[0], pool_seq[0] + 1, 16'd40, now_ns);
        queue_timed(KIND_RSP, pool_key[0], pool_seq[0] + 1, 16'd40, now_ns + 500);
        queue_item(KIND_CLR, '0, 0, 0, 0, 0);
        queue_timed(KIND_REQ, pool_key[1], pool_seq[1] + 1, 16'd40, now_ns);
        drain();

        $display("%0d transactions in, %0d results checked (%0d matched responses, %0d full-table)",
                 items_accepted, results_checked, matched_seen, full_seen);
        $display("limits swept through zero, reset and full scale; %0d mismatches", mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
